// ===== hw/rtl/gdfs_pkg.sv =====
// shared types and constants of the depth-first search block
package gdfs_pkg;

  // item actions
  localparam logic [1:0] ACT_ARC   = 2'd0;
  localparam logic [1:0] ACT_EDGE  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_ORDER = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  // vertex count after reset
  localparam logic [6:0] VCOUNT_RESET = 7'd64;

  // datapath operations, one per controller step
  typedef enum logic [3:0] {
    OP_IDLE      = 4'd0,
    OP_DECODE    = 4'd1,
    OP_ARC_RD    = 4'd2,
    OP_ARC_WR    = 4'd3,
    OP_EDGE_RD   = 4'd4,
    OP_EDGE_WR   = 4'd5,
    OP_REPLY     = 4'd6,
    OP_INIT      = 4'd7,
    OP_ROOT_RD   = 4'd8,
    OP_ROOT      = 4'd9,
    OP_ROOT_NEXT = 4'd10,
    OP_SCAN      = 4'd11,
    OP_POP       = 4'd12,
    OP_OUT_RD    = 4'd13,
    OP_OUT_V     = 4'd14,
    OP_OUT_EMIT  = 4'd15
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       pair_ok;
    logic       search_go;
    logic       found;
    logic       sp_one;
    logic       root_white;
    logic       r_end;
    logic       done_one;
  } stat_t;

endpackage

// ===== hw/rtl/gdfs_datapath.sv =====
// datapath: adjacency memory, search stores, stack and result registers
module gdfs_datapath #(
  parameter int MAX_VERTICES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  gdfs_pkg::cmd_t   cmd,
  output gdfs_pkg::stat_t  stat,
  input  logic [1:0]       action,
  input  logic [6:0]       first_vertex,
  input  logic [6:0]       second_vertex,
  input  logic             last_in_order,
  input  logic             wr_en,
  input  logic [6:0]       wr_data,
  output logic             result_strobe,
  output logic [1:0]       status,
  output logic [15:0]      edge_count,
  output logic [6:0]       vertex,
  output logic [7:0]       discover_time,
  output logic [7:0]       finish_time,
  output logic [6:0]       parent,
  output logic             last_result
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam logic [6:0] MAXV = 7'(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

  // configuration and latched item
  logic [6:0] vcount;
  logic [1:0] it_act;
  logic [6:0] it_a;
  logic [6:0] it_b;
  logic       it_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= gdfs_pkg::VCOUNT_RESET;
    end else if (wr_en) begin
      vcount <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_act  <= action;
      it_a    <= first_vertex;
      it_b    <= second_vertex;
      it_last <= last_in_order;
    end
  end

  // active vertex count and live mask
  logic [6:0] n;
  logic [MAX_VERTICES-1:0] live;
  always_comb begin
    if (vcount == 7'd0) n = 7'd1;
    else if (vcount > MAXV) n = MAXV;
    else n = vcount;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live[i] = (7'(i) < n);
    end
  end

  // item decode
  logic [6:0] a_m1, b_m1;
  logic [IW-1:0] ai, bi;
  logic a_ok, b_ok;
  logic [MAX_VERTICES-1:0] a_hot, b_hot;
  assign a_m1  = it_a - 7'd1;
  assign b_m1  = it_b - 7'd1;
  assign ai    = a_m1[IW-1:0];
  assign bi    = b_m1[IW-1:0];
  assign a_ok  = (it_a != 7'd0) && (it_a <= n);
  assign b_ok  = (it_b != 7'd0) && (it_b <= n);
  assign a_hot = ONE << ai;
  assign b_hot = ONE << bi;

  // order list checks
  logic [6:0] ord_len;
  logic [MAX_VERTICES-1:0] seen;
  logic [MAX_VERTICES-1:0] seen_new;
  logic [6:0] len_new;
  logic [1:0] st0, fin_st, ord_st, dec_st;
  logic       search_go;

  assign seen_new = seen | a_hot;
  assign len_new  = ord_len + 7'd1;

  always_comb begin
    if (!a_ok) st0 = gdfs_pkg::ST_RANGE;
    else if ((seen & a_hot) != '0) st0 = gdfs_pkg::ST_ORDER;
    else if (ord_len >= MAXV) st0 = gdfs_pkg::ST_ORDER;
    else st0 = gdfs_pkg::ST_OK;

    if (st0 != gdfs_pkg::ST_OK) fin_st = st0;
    else if (len_new != n) fin_st = gdfs_pkg::ST_ORDER;
    else if ((seen_new & ~live) != '0) fin_st = gdfs_pkg::ST_RANGE;
    else fin_st = gdfs_pkg::ST_OK;

    ord_st    = it_last ? fin_st : st0;
    search_go = (it_act == gdfs_pkg::ACT_ORDER) && it_last && (fin_st == gdfs_pkg::ST_OK);

    case (it_act)
      gdfs_pkg::ACT_ARC,
      gdfs_pkg::ACT_EDGE:  dec_st = (a_ok && b_ok) ? gdfs_pkg::ST_OK : gdfs_pkg::ST_RANGE;
      gdfs_pkg::ACT_CLEAR: dec_st = gdfs_pkg::ST_OK;
      default:             dec_st = ord_st;
    endcase
  end

  // search registers
  logic [MAX_VERTICES-1:0] white;
  logic [7:0] stamp;
  logic [6:0] r, sp, cur, done_cnt;
  logic [1:0] res_st;
  logic [15:0] arc_total;

  // registered memory read data
  logic [MAX_VERTICES-1:0] row_q;
  logic       row_v_q;
  logic [6:0] ord_q, stk_q, fo_q, par_q;
  logic [7:0] dis_q, fin_q;

  logic [6:0] ord_m1, stk_m1, fo_m1, cur_m1, sp_m1, sp_m2, done_m1;
  logic [IW-1:0] root_i, pop_i, fo_i, cur_i;
  assign ord_m1  = ord_q - 7'd1;
  assign stk_m1  = stk_q - 7'd1;
  assign fo_m1   = fo_q - 7'd1;
  assign cur_m1  = cur - 7'd1;
  assign sp_m1   = sp - 7'd1;
  assign sp_m2   = sp - 7'd2;
  assign done_m1 = done_cnt - 7'd1;
  assign root_i  = ord_m1[IW-1:0];
  assign pop_i   = stk_m1[IW-1:0];
  assign fo_i    = fo_m1[IW-1:0];
  assign cur_i   = cur_m1[IW-1:0];

  // first white live neighbour of the current vertex
  logic [MAX_VERTICES-1:0] row_eff, cand;
  logic [IW-1:0] j;
  logic found, root_white;
  assign row_eff    = row_q & {MAX_VERTICES{row_v_q}};
  assign cand       = row_eff & white & live;
  assign found      = (cand != '0);
  assign root_white = white[root_i];
  always_comb begin
    j = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) j = IW'(i);
    end
  end

  logic [7:0] stamp_inc;
  logic [6:0] j_p1;
  assign stamp_inc = stamp + 8'd1;
  assign j_p1      = 7'(j) + 7'd1;

  // status to the controller
  assign stat.act        = it_act;
  assign stat.pair_ok    = a_ok && b_ok;
  assign stat.search_go  = search_go;
  assign stat.found      = found;
  assign stat.sp_one     = (sp == 7'd1);
  assign stat.root_white = root_white;
  assign stat.r_end      = (r == n);
  assign stat.done_one   = (done_cnt == 7'd1);

  // adjacency memory with per-row valid bits
  logic [MAX_VERTICES-1:0] rows_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rvalid;
  logic row_re, row_we;
  logic [IW-1:0] row_ra, row_wa;
  logic [MAX_VERTICES-1:0] row_wd;

  always_comb begin
    row_re = 1'b0;
    row_ra = ai;
    row_we = 1'b0;
    row_wa = ai;
    row_wd = row_eff | b_hot;
    case (cmd.op)
      gdfs_pkg::OP_ARC_RD:  row_re = 1'b1;
      gdfs_pkg::OP_EDGE_RD: begin
        row_re = 1'b1;
        row_ra = bi;
      end
      gdfs_pkg::OP_ARC_WR:  row_we = 1'b1;
      gdfs_pkg::OP_EDGE_WR: begin
        row_we = 1'b1;
        row_wa = bi;
        row_wd = row_eff | a_hot;
      end
      gdfs_pkg::OP_ROOT: begin
        row_re = root_white;
        row_ra = root_i;
      end
      gdfs_pkg::OP_SCAN: begin
        row_re = found;
        row_ra = j;
      end
      gdfs_pkg::OP_POP: begin
        row_re = 1'b1;
        row_ra = pop_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (row_we) rows_mem[row_wa] <= row_wd;
    if (row_re) begin
      row_q   <= rows_mem[row_ra];
      row_v_q <= rvalid[row_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= '0;
    end else if (cmd.op == gdfs_pkg::OP_DECODE && it_act == gdfs_pkg::ACT_CLEAR) begin
      rvalid <= '0;
    end else if (row_we) begin
      rvalid[row_wa] <= 1'b1;
    end
  end

  // order list memory
  logic [6:0] ord_mem [MAX_VERTICES];
  logic ord_we;
  assign ord_we = (cmd.op == gdfs_pkg::OP_DECODE) && (it_act == gdfs_pkg::ACT_ORDER)
                  && (st0 == gdfs_pkg::ST_OK);
  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_len[IW-1:0]] <= it_a;
    if (cmd.op == gdfs_pkg::OP_ROOT_RD && !stat.r_end) ord_q <= ord_mem[r[IW-1:0]];
  end

  // walk stack, entries below the top of stack
  logic [6:0] stk_mem [MAX_VERTICES];
  always_ff @(posedge clk) begin
    if (cmd.op == gdfs_pkg::OP_SCAN && found) stk_mem[sp_m1[IW-1:0]] <= cur;
    if (cmd.op == gdfs_pkg::OP_SCAN && !found && sp != 7'd1) stk_q <= stk_mem[sp_m2[IW-1:0]];
  end

  // parent and discovery stores
  logic [6:0] par_mem [MAX_VERTICES];
  logic [7:0] dis_mem [MAX_VERTICES];
  logic pd_we;
  logic [IW-1:0] pd_wa;
  logic [6:0] par_wd;
  assign pd_we  = (cmd.op == gdfs_pkg::OP_ROOT && root_white)
                  || (cmd.op == gdfs_pkg::OP_SCAN && found);
  assign pd_wa  = (cmd.op == gdfs_pkg::OP_ROOT) ? root_i : j;
  assign par_wd = (cmd.op == gdfs_pkg::OP_ROOT) ? 7'd0 : cur;
  always_ff @(posedge clk) begin
    if (pd_we) begin
      par_mem[pd_wa] <= par_wd;
      dis_mem[pd_wa] <= stamp_inc;
    end
    if (cmd.op == gdfs_pkg::OP_OUT_V) begin
      par_q <= par_mem[fo_i];
      dis_q <= dis_mem[fo_i];
    end
  end

  // finish store and finish order list
  logic [7:0] fin_mem [MAX_VERTICES];
  logic [6:0] fo_mem [MAX_VERTICES];
  logic fin_we;
  assign fin_we = (cmd.op == gdfs_pkg::OP_SCAN) && !found;
  always_ff @(posedge clk) begin
    if (fin_we) begin
      fin_mem[cur_i] <= stamp_inc;
      fo_mem[done_cnt[IW-1:0]] <= cur;
    end
    if (cmd.op == gdfs_pkg::OP_OUT_V) fin_q <= fin_mem[fo_i];
    if (cmd.op == gdfs_pkg::OP_OUT_RD) fo_q <= fo_mem[done_m1[IW-1:0]];
  end

  // control registers of the order list, arc count and search
  always_ff @(posedge clk) begin
    if (rst) begin
      ord_len   <= 7'd0;
      seen      <= '0;
      arc_total <= 16'd0;
      white     <= '0;
      stamp     <= 8'd0;
      r         <= 7'd0;
      sp        <= 7'd0;
      cur       <= 7'd0;
      done_cnt  <= 7'd0;
      res_st    <= gdfs_pkg::ST_OK;
    end else begin
      case (cmd.op)
        gdfs_pkg::OP_DECODE: begin
          res_st <= dec_st;
          if (it_act == gdfs_pkg::ACT_CLEAR) arc_total <= 16'd0;
          if (it_act == gdfs_pkg::ACT_ORDER) begin
            if (it_last) begin
              ord_len <= 7'd0;
              seen    <= '0;
            end else if (st0 == gdfs_pkg::ST_OK) begin
              ord_len <= len_new;
              seen    <= seen_new;
            end
          end
        end
        gdfs_pkg::OP_ARC_WR: begin
          if (arc_total != 16'hFFFF) arc_total <= arc_total + 16'd1;
        end
        gdfs_pkg::OP_INIT: begin
          white    <= '1;
          stamp    <= 8'd0;
          r        <= 7'd0;
          done_cnt <= 7'd0;
        end
        gdfs_pkg::OP_ROOT: begin
          if (root_white) begin
            stamp         <= stamp_inc;
            white[root_i] <= 1'b0;
            cur           <= ord_q;
            sp            <= 7'd1;
          end
        end
        gdfs_pkg::OP_ROOT_NEXT: r <= r + 7'd1;
        gdfs_pkg::OP_SCAN: begin
          stamp <= stamp_inc;
          if (found) begin
            white[j] <= 1'b0;
            cur      <= j_p1;
            sp       <= sp + 7'd1;
          end else begin
            done_cnt <= done_cnt + 7'd1;
            sp       <= sp_m1;
          end
        end
        gdfs_pkg::OP_POP: cur <= stk_q;
        gdfs_pkg::OP_OUT_EMIT: done_cnt <= done_m1;
        default: ;
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (cmd.op == gdfs_pkg::OP_REPLY) || (cmd.op == gdfs_pkg::OP_OUT_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    edge_count <= arc_total;
    if (cmd.op == gdfs_pkg::OP_OUT_EMIT) begin
      status        <= gdfs_pkg::ST_OK;
      vertex        <= fo_q;
      discover_time <= dis_q;
      finish_time   <= fin_q;
      parent        <= par_q;
      last_result   <= (done_cnt == 7'd1);
    end else begin
      status        <= res_st;
      vertex        <= 7'd0;
      discover_time <= 8'd0;
      finish_time   <= 8'd0;
      parent        <= 7'd0;
      last_result   <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/gdfs_ctrl.sv =====
// controller state machine sequencing item handling, search and result output
module gdfs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  gdfs_pkg::stat_t stat,
  output gdfs_pkg::cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_DECODE    = 16'h0002,
    S_ARC_RD    = 16'h0004,
    S_ARC_WR    = 16'h0008,
    S_EDGE_RD   = 16'h0010,
    S_EDGE_WR   = 16'h0020,
    S_REPLY     = 16'h0040,
    S_INIT      = 16'h0080,
    S_ROOT_RD   = 16'h0100,
    S_ROOT      = 16'h0200,
    S_ROOT_NEXT = 16'h0400,
    S_SCAN      = 16'h0800,
    S_POP       = 16'h1000,
    S_OUT_RD    = 16'h2000,
    S_OUT_V     = 16'h4000,
    S_OUT_EMIT  = 16'h8000
  } state_t;

  state_t state, state_next;

  assign busy     = (state != S_IDLE);
  assign cmd.load = (state == S_IDLE) && start;

  // next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op     = gdfs_pkg::OP_IDLE;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.op = gdfs_pkg::OP_DECODE;
        if ((stat.act == gdfs_pkg::ACT_ARC || stat.act == gdfs_pkg::ACT_EDGE) && stat.pair_ok)
          state_next = S_ARC_RD;
        else if (stat.search_go)
          state_next = S_INIT;
        else
          state_next = S_REPLY;
      end
      S_ARC_RD: begin
        cmd.op     = gdfs_pkg::OP_ARC_RD;
        state_next = S_ARC_WR;
      end
      S_ARC_WR: begin
        cmd.op     = gdfs_pkg::OP_ARC_WR;
        state_next = (stat.act == gdfs_pkg::ACT_EDGE) ? S_EDGE_RD : S_REPLY;
      end
      S_EDGE_RD: begin
        cmd.op     = gdfs_pkg::OP_EDGE_RD;
        state_next = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        cmd.op     = gdfs_pkg::OP_EDGE_WR;
        state_next = S_REPLY;
      end
      S_REPLY: begin
        cmd.op     = gdfs_pkg::OP_REPLY;
        state_next = S_IDLE;
      end
      S_INIT: begin
        cmd.op     = gdfs_pkg::OP_INIT;
        state_next = S_ROOT_RD;
      end
      S_ROOT_RD: begin
        cmd.op     = gdfs_pkg::OP_ROOT_RD;
        state_next = stat.r_end ? S_OUT_RD : S_ROOT;
      end
      S_ROOT: begin
        cmd.op     = gdfs_pkg::OP_ROOT;
        state_next = stat.root_white ? S_SCAN : S_ROOT_NEXT;
      end
      S_ROOT_NEXT: begin
        cmd.op     = gdfs_pkg::OP_ROOT_NEXT;
        state_next = S_ROOT_RD;
      end
      S_SCAN: begin
        cmd.op = gdfs_pkg::OP_SCAN;
        if (stat.found) state_next = S_SCAN;
        else if (stat.sp_one) state_next = S_ROOT_NEXT;
        else state_next = S_POP;
      end
      S_POP: begin
        cmd.op     = gdfs_pkg::OP_POP;
        state_next = S_SCAN;
      end
      S_OUT_RD: begin
        cmd.op     = gdfs_pkg::OP_OUT_RD;
        state_next = S_OUT_V;
      end
      S_OUT_V: begin
        cmd.op     = gdfs_pkg::OP_OUT_V;
        state_next = S_OUT_EMIT;
      end
      S_OUT_EMIT: begin
        cmd.op     = gdfs_pkg::OP_OUT_EMIT;
        state_next = stat.done_one ? S_IDLE : S_OUT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/graph_depth_first_search.sv =====
// top level of the depth-first search block
// Usage: drive an item on action, first_vertex, second_vertex and last_in_order
// with start high; it is taken at a clock edge where busy is low. Each item gives
// results on the result ports, one per cycle of result_strobe, with last_result
// on the final one; the receiver cannot hold results off.
// The last order item runs the search: a root test per order list entry plus a stack
// walk per vertex visit (one adjacency row read per step), then the results.
// One item is handled at a time.
// vertex_count is written with wr_en and wr_data while the block is idle; the user
// must keep to this, as the block itself does not enforce it.
// Reset (rst, synchronous) empties the graph, the order list and the arc count,
// sets vertex_count to 64 and leaves the block idle at once; no clearing pass.
module graph_depth_first_search #(
  parameter int MAX_VERTICES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [6:0]  first_vertex,
  input  logic [6:0]  second_vertex,
  input  logic        last_in_order,
  input  logic        wr_en,
  input  logic [6:0]  wr_data,
  output logic        result_strobe,
  output logic [1:0]  status,
  output logic [15:0] edge_count,
  output logic [6:0]  vertex,
  output logic [7:0]  discover_time,
  output logic [7:0]  finish_time,
  output logic [6:0]  parent,
  output logic        last_result
);

  gdfs_pkg::cmd_t  cmd;
  gdfs_pkg::stat_t stat;

  // controller
  gdfs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath
  gdfs_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (action),
    .first_vertex  (first_vertex),
    .second_vertex (second_vertex),
    .last_in_order (last_in_order),
    .wr_en         (wr_en),
    .wr_data       (wr_data),
    .result_strobe (result_strobe),
    .status        (status),
    .edge_count    (edge_count),
    .vertex        (vertex),
    .discover_time (discover_time),
    .finish_time   (finish_time),
    .parent        (parent),
    .last_result   (last_result)
  );

endmodule
